[rtl/b40_pkg.sv]
`timescale 1ns / 1ps
package b40_pkg;

    localparam int unsigned SYMBOL_COUNT = 40;
    localparam int unsigned DIGIT_W      = 6;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned WORD_W       = 16;
    localparam int unsigned COUNT_W      = 2;

    localparam logic [WORD_W-1:0] RADIX        = WORD_W'(SYMBOL_COUNT);
    localparam logic [WORD_W-1:0] RADIX_SQ     = WORD_W'(SYMBOL_COUNT * SYMBOL_COUNT);
    localparam logic [15:0]       DIV5_RECIP   = 16'd52429;
    localparam logic [12:0]       DIV25_RECIP  = 13'd5243;

    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_QUERY = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
    localparam logic [BYTE_W-1:0] CH_Z     = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;

    localparam logic [DIGIT_W-1:0] IDX_SPACE = 6'd0;
    localparam logic [DIGIT_W-1:0] IDX_QUERY = 6'd1;
    localparam logic [DIGIT_W-1:0] IDX_ZERO  = 6'd2;
    localparam logic [DIGIT_W-1:0] IDX_NINE  = 6'd11;
    localparam logic [DIGIT_W-1:0] IDX_A     = 6'd12;
    localparam logic [DIGIT_W-1:0] IDX_Z     = 6'd37;
    localparam logic [DIGIT_W-1:0] IDX_PLUS  = 6'd38;
    localparam logic [DIGIT_W-1:0] IDX_MINUS = 6'd39;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } t_op;

    function automatic logic [DIGIT_W-1:0] symbol_index(input logic [BYTE_W-1:0] ch);
        logic [DIGIT_W-1:0] idx;
        idx = IDX_SPACE;
        if (ch == CH_QUERY) begin
            idx = IDX_QUERY;
        end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
            idx = DIGIT_W'(ch - CH_ZERO) + IDX_ZERO;
        end else if (ch >= CH_A && ch <= CH_Z) begin
            idx = DIGIT_W'(ch - CH_A) + IDX_A;
        end else if (ch == CH_PLUS) begin
            idx = IDX_PLUS;
        end else if (ch == CH_MINUS) begin
            idx = IDX_MINUS;
        end
        return idx;
    endfunction

    function automatic logic [BYTE_W-1:0] symbol_byte(input logic [DIGIT_W-1:0] d);
        logic [BYTE_W-1:0] ch;
        ch = CH_SPACE;
        if (d == IDX_QUERY) begin
            ch = CH_QUERY;
        end else if (d >= IDX_ZERO && d <= IDX_NINE) begin
            ch = BYTE_W'(d - IDX_ZERO) + CH_ZERO;
        end else if (d >= IDX_A && d <= IDX_Z) begin
            ch = BYTE_W'(d - IDX_A) + CH_A;
        end else if (d == IDX_PLUS) begin
            ch = CH_PLUS;
        end else if (d == IDX_MINUS) begin
            ch = CH_MINUS;
        end
        return ch;
    endfunction

endpackage

[rtl/b40_in_if.sv]
`timescale 1ns / 1ps
interface b40_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [7:0]  char_first;
    logic [7:0]  char_second;
    logic [7:0]  char_third;
    logic [1:0]  char_count;
    logic [15:0] packed_in;

    modport source (
        output valid, operation, char_first, char_second, char_third, char_count, packed_in,
        input  ready
    );
    modport sink (
        input  valid, operation, char_first, char_second, char_third, char_count, packed_in,
        output ready
    );
endinterface

[rtl/b40_out_if.sv]
`timescale 1ns / 1ps
interface b40_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] packed_out;
    logic [7:0]  out_first;
    logic [7:0]  out_second;
    logic [7:0]  out_third;

    modport source (
        output valid, packed_out, out_first, out_second, out_third,
        input  ready
    );
    modport sink (
        input  valid, packed_out, out_first, out_second, out_third,
        output ready
    );
endinterface

[rtl/base40_name_pack_unpack_unit.sv]
`timescale 1ns / 1ps
// A transaction passes the input register, the mapping logic, then the result register.
// Throughput: one transaction per cycle unless the output stalls the result register.
// Input ready stays high while the result register drains or is free.
// Reset: synchronous, active low; clears both valid flags, payload registers are not reset.
module base40_name_pack_unpack_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    b40_in_if.sink    i_in,
    b40_out_if.source o_out
);
    logic                          r_in_valid;
    logic                          r_op;
    logic [b40_pkg::BYTE_W-1:0]    r_c0;
    logic [b40_pkg::BYTE_W-1:0]    r_c1;
    logic [b40_pkg::BYTE_W-1:0]    r_c2;
    logic [b40_pkg::COUNT_W-1:0]   r_count;
    logic [b40_pkg::WORD_W-1:0]    r_word;

    logic                          r_out_valid;
    logic [b40_pkg::WORD_W-1:0]    r_packed;
    logic [b40_pkg::BYTE_W-1:0]    r_b0;
    logic [b40_pkg::BYTE_W-1:0]    r_b1;
    logic [b40_pkg::BYTE_W-1:0]    r_b2;

    logic [b40_pkg::WORD_W-1:0]    n_packed;
    logic [b40_pkg::BYTE_W-1:0]    n_b0;
    logic [b40_pkg::BYTE_W-1:0]    n_b1;
    logic [b40_pkg::BYTE_W-1:0]    n_b2;

    logic [b40_pkg::WORD_W-1:0]    w_enc;
    logic [b40_pkg::BYTE_W-1:0]    w_dec0;
    logic [b40_pkg::BYTE_W-1:0]    w_dec1;
    logic [b40_pkg::BYTE_W-1:0]    w_dec2;
    logic                          w_in_take;
    logic                          w_out_load;

    b40_enc u_enc (
        .i_char_first  (r_c0),
        .i_char_second (r_c1),
        .i_char_third  (r_c2),
        .i_char_count  (r_count),
        .o_packed      (w_enc)
    );

    b40_dec u_dec (
        .i_word   (r_word),
        .o_first  (w_dec0),
        .o_second (w_dec1),
        .o_third  (w_dec2)
    );

    assign w_out_load = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_out_load;
    assign w_in_take  = i_in.valid && i_in.ready;

    always_comb begin
        if (r_op == b40_pkg::OP_DECODE) begin
            n_packed = '0;
            n_b0     = w_dec0;
            n_b1     = w_dec1;
            n_b2     = w_dec2;
        end else begin
            n_packed = w_enc;
            n_b0     = '0;
            n_b1     = '0;
            n_b2     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_out_load) begin
                r_in_valid <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_op    <= i_in.operation;
            r_c0    <= i_in.char_first;
            r_c1    <= i_in.char_second;
            r_c2    <= i_in.char_third;
            r_count <= i_in.char_count;
            r_word  <= i_in.packed_in;
        end
        if (w_out_load) begin
            r_packed <= n_packed;
            r_b0     <= n_b0;
            r_b1     <= n_b1;
            r_b2     <= n_b2;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.packed_out = r_packed;
    assign o_out.out_first  = r_b0;
    assign o_out.out_second = r_b1;
    assign o_out.out_third  = r_b2;

`ifndef SYNTHESIS
    a_take_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> r_in_valid)
        else $error("input transaction did not fill the input register");

    a_packed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_packed < 16'd64000))
        else $error("packed result out of base-40 range");

    a_encode_no_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_packed != '0) |-> (r_b0 == '0 && r_b1 == '0 && r_b2 == '0))
        else $error("encode result carries decoded bytes");

    a_decode_bytes_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_b0 != '0) |-> (r_b1 != '0 && r_b2 != '0 && r_packed == '0))
        else $error("decode result incomplete");
`endif
endmodule

[rtl/b40_enc.sv]
`timescale 1ns / 1ps
module b40_enc (
    input  logic [b40_pkg::BYTE_W-1:0]  i_char_first,
    input  logic [b40_pkg::BYTE_W-1:0]  i_char_second,
    input  logic [b40_pkg::BYTE_W-1:0]  i_char_third,
    input  logic [b40_pkg::COUNT_W-1:0] i_char_count,
    output logic [b40_pkg::WORD_W-1:0]  o_packed
);
    logic [b40_pkg::DIGIT_W-1:0] w_idx0;
    logic [b40_pkg::DIGIT_W-1:0] w_idx1;
    logic [b40_pkg::DIGIT_W-1:0] w_idx2;
    logic [b40_pkg::WORD_W-1:0]  w_one;
    logic [b40_pkg::WORD_W-1:0]  w_two;
    logic [b40_pkg::WORD_W-1:0]  w_three;

    assign w_idx0 = b40_pkg::symbol_index(i_char_first);
    assign w_idx1 = b40_pkg::symbol_index(i_char_second);
    assign w_idx2 = b40_pkg::symbol_index(i_char_third);

    assign w_one   = b40_pkg::WORD_W'(w_idx0);
    assign w_two   = b40_pkg::WORD_W'(w_idx0) * b40_pkg::RADIX + b40_pkg::WORD_W'(w_idx1);
    assign w_three = b40_pkg::WORD_W'(w_idx0) * b40_pkg::RADIX_SQ
                   + b40_pkg::WORD_W'(w_idx1) * b40_pkg::RADIX
                   + b40_pkg::WORD_W'(w_idx2);

    always_comb begin
        case (i_char_count)
            2'd0:    o_packed = '0;
            2'd1:    o_packed = w_one;
            2'd2:    o_packed = w_two;
            2'd3:    o_packed = w_three;
            default: o_packed = '0;
        endcase
    end
endmodule

[rtl/b40_dec.sv]
`timescale 1ns / 1ps
module b40_dec (
    input  logic [b40_pkg::WORD_W-1:0] i_word,
    output logic [b40_pkg::BYTE_W-1:0] o_first,
    output logic [b40_pkg::BYTE_W-1:0] o_second,
    output logic [b40_pkg::BYTE_W-1:0] o_third
);
    logic [12:0] w_eighth;
    logic [28:0] w_q_prod;
    logic [10:0] w_q;
    logic [9:0]  w_sixtyfourth;
    logic [22:0] w_t_prod;
    logic [5:0]  w_t;
    logic [b40_pkg::WORD_W-1:0] w_rem2;
    logic [10:0] w_rem1;
    logic [b40_pkg::DIGIT_W-1:0] w_d0;
    logic [b40_pkg::DIGIT_W-1:0] w_d1;
    logic [b40_pkg::DIGIT_W-1:0] w_d2;

    // word / 40 and word / 1600 by reciprocal multiply
    assign w_eighth      = i_word[15:3];
    assign w_q_prod      = 29'(w_eighth) * 29'(b40_pkg::DIV5_RECIP);
    assign w_q           = w_q_prod[28:18];
    assign w_sixtyfourth = i_word[15:6];
    assign w_t_prod      = 23'(w_sixtyfourth) * 23'(b40_pkg::DIV25_RECIP);
    assign w_t           = w_t_prod[22:17];

    assign w_rem2 = i_word - b40_pkg::WORD_W'(w_q) * b40_pkg::RADIX;
    assign w_rem1 = w_q - 11'(w_t) * 11'(b40_pkg::SYMBOL_COUNT);

    assign w_d2 = w_rem2[b40_pkg::DIGIT_W-1:0];
    assign w_d1 = w_rem1[b40_pkg::DIGIT_W-1:0];
    assign w_d0 = (w_t == b40_pkg::DIGIT_W'(b40_pkg::SYMBOL_COUNT)) ? '0 : w_t;

    assign o_first  = b40_pkg::symbol_byte(w_d0);
    assign o_second = b40_pkg::symbol_byte(w_d1);
    assign o_third  = b40_pkg::symbol_byte(w_d2);
endmodule
